// ----- sv/fdr_pkg.sv -----
// Shared field widths and fixed-point constants for the Fresnel reflectance block.
package fdr_pkg;
    localparam int ETA_W = 16;
    localparam int COS_W = 16;
    localparam int OUT_W = 16;
    localparam int CLAMP_W = 15;
    localparam logic [CLAMP_W-1:0] COS_ONE = 15'd16384;
    localparam logic [28:0] ONE_Q28 = 29'h1000_0000;
    localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;
endpackage

// ----- sv/fdr_div.sv -----
// Pipelined restoring fraction divider: one quotient bit per stage, n >= d or d == 0 gives one.
module fdr_div #(
    parameter int NW = 36,
    parameter int QB = 30,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QB:0]   o_quot,
    output logic [SW-1:0] o_side
);
    logic [QB-1:0] r_v;
    logic [QB-1:0] r_sat;
    logic [NW-1:0] r_rem  [QB];
    logic [NW-1:0] r_den  [QB];
    logic [QB-1:0] r_q    [QB];
    logic [SW-1:0] r_side [QB];

    logic [QB-1:0] p_v;
    logic [QB-1:0] p_sat;
    logic [NW-1:0] p_rem  [QB];
    logic [NW-1:0] p_den  [QB];
    logic [QB-1:0] p_q    [QB];
    logic [SW-1:0] p_side [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [NW:0]   sh;
        logic          ge;
        logic [NW-1:0] n_rem;
        logic [QB-1:0] n_q;

        if (k == 0) begin : g_first
            assign p_v[k]    = i_valid;
            assign p_sat[k]  = (i_den == '0) || (i_num >= i_den);
            assign p_rem[k]  = i_num;
            assign p_den[k]  = i_den;
            assign p_q[k]    = '0;
            assign p_side[k] = i_side;
        end else begin : g_next
            assign p_v[k]    = r_v[k-1];
            assign p_sat[k]  = r_sat[k-1];
            assign p_rem[k]  = r_rem[k-1];
            assign p_den[k]  = r_den[k-1];
            assign p_q[k]    = r_q[k-1];
            assign p_side[k] = r_side[k-1];
        end

        always_comb begin
            sh    = {p_rem[k], 1'b0};
            ge    = sh >= {1'b0, p_den[k]};
            n_rem = ge ? NW'(sh - {1'b0, p_den[k]}) : sh[NW-1:0];
            n_q   = QB'({p_q[k], ge});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[k]  <= p_sat[k];
                r_rem[k]  <= n_rem;
                r_den[k]  <= p_den[k];
                r_q[k]    <= n_q;
                r_side[k] <= p_side[k];
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_quot  = r_sat[QB-1] ? {1'b1, QB'(0)} : {1'b0, r_q[QB-1]};
    assign o_side  = r_side[QB-1];
endmodule

// ----- sv/fdr_sqrt.sv -----
// Pipelined digit-by-digit integer square root: one root bit per stage.
module fdr_sqrt #(
    parameter int RB = 15,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RB-1:0] i_x,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RB-1:0]   o_root,
    output logic [SW-1:0]   o_side
);
    logic [RB-1:0]   r_v;
    logic [2*RB-1:0] r_x    [RB];
    logic [RB+1:0]   r_rem  [RB];
    logic [RB-1:0]   r_root [RB];
    logic [SW-1:0]   r_side [RB];

    logic [RB-1:0]   p_v;
    logic [2*RB-1:0] p_x    [RB];
    logic [RB+1:0]   p_rem  [RB];
    logic [RB-1:0]   p_root [RB];
    logic [SW-1:0]   p_side [RB];

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RB+3:0] cur;
        logic [RB+3:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_v[k]    = i_valid;
            assign p_x[k]    = i_x;
            assign p_rem[k]  = '0;
            assign p_root[k] = '0;
            assign p_side[k] = i_side;
        end else begin : g_next
            assign p_v[k]    = r_v[k-1];
            assign p_x[k]    = r_x[k-1];
            assign p_rem[k]  = r_rem[k-1];
            assign p_root[k] = r_root[k-1];
            assign p_side[k] = r_side[k-1];
        end

        always_comb begin
            cur   = {p_rem[k], p_x[k][2*RB-1:2*RB-2]};
            trial = {2'b00, p_root[k], 2'b01};
            ge    = cur >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= {p_x[k][2*RB-3:0], 2'b00};
                r_rem[k]  <= ge ? (RB+2)'(cur - trial) : (RB+2)'(cur);
                r_root[k] <= RB'({p_root[k], ge});
                r_side[k] <= p_side[k];
            end
        end
    end

    assign o_valid = r_v[RB-1];
    assign o_root  = r_root[RB-1];
    assign o_side  = r_side[RB-1];
endmodule

// ----- sv/dielectric_fresnel_reflectance.sv -----
// Top level: pipelined unpolarized dielectric Fresnel reflectance.
//   channel | handshake          | payload
//   input   | i_valid / o_ready  | i_eta_ratio, i_cos_transmitted
//   output  | o_valid / i_ready  | o_reflectance, o_cos_incident, o_total_reflection
// One transfer per cycle in each direction while the output is not stalled; the pipeline
// holds 2F divider stages, F+1 root stages, F ratio-divider stages and six arithmetic stages.
// Reset clears only the stage valid bits. A stall on the output freezes the whole
// pipeline; o_ready is high whenever the output register is empty or being taken.
module dielectric_fresnel_reflectance #(
    parameter int OUT_FRAC_BITS = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [fdr_pkg::ETA_W-1:0]  i_eta_ratio,
    input  logic signed [fdr_pkg::COS_W-1:0] i_cos_transmitted,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [fdr_pkg::OUT_W-1:0]  o_reflectance,
    output logic [fdr_pkg::OUT_W-1:0]  o_cos_incident,
    output logic                       o_total_reflection
);
    import fdr_pkg::*;

    localparam int F   = OUT_FRAC_BITS;
    localparam int NW1 = 36;
    localparam int NWP = F + 31;
    localparam int NWS = F + 17;
    localparam int SW1 = 1 + ETA_W + CLAMP_W + 30;
    localparam int SQW = 2 * F + 3;
    localparam logic [OUT_W-1:0] ONE_SAT =
        (F > 15) ? OUT_MAX : OUT_W'(64'd1 << F);

    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // stage 0: clamp and products
    logic               r_v0;
    logic [ETA_W-1:0]   r_eta0;
    logic [CLAMP_W-1:0] r_c0;
    logic [28:0]        r_cc0;
    logic [31:0]        r_ee0;
    logic [29:0]        r_ec0;
    logic [CLAMP_W-1:0] n_c;

    always_comb begin
        if (i_cos_transmitted[COS_W-1]) begin
            n_c = '0;
        end else if (i_cos_transmitted > $signed({1'b0, COS_ONE})) begin
            n_c = COS_ONE;
        end else begin
            n_c = i_cos_transmitted[CLAMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_eta0 <= i_eta_ratio;
            r_c0   <= n_c;
            r_cc0  <= 29'(n_c) * 29'(n_c);
            r_ee0  <= i_eta_ratio * i_eta_ratio;
            r_ec0  <= 30'(i_eta_ratio) * 30'(n_c);
        end
    end

    // stage 1: Snell test and divider operands
    logic               r_v1;
    logic               r_tir1;
    logic [NW1-1:0]     r_num1;
    logic [NW1-1:0]     r_den1;
    logic [SW1-2:0]     r_pass1;
    logic [28:0]        sin2_t;
    logic [NW1-1:0]     eta2s;

    assign sin2_t = ONE_Q28 - r_cc0;
    assign eta2s  = {r_ee0, 4'b0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tir1  <= (r_eta0 == '0) || ({7'd0, sin2_t} >= eta2s);
            r_num1  <= eta2s - {7'd0, sin2_t};
            r_den1  <= eta2s;
            r_pass1 <= {r_eta0, r_c0, r_ec0};
        end
    end

    // 1 - sin2_i, then its root; the quotient reaches one at normal incidence
    logic           d1_v;
    logic [2*F:0]   d1_q;
    logic [SW1-1:0] d1_side;
    logic           sq_v;
    logic [F:0]     sq_root;
    logic [SW1-1:0] sq_side;

    fdr_div #(.NW(NW1), .QB(2 * F), .SW(SW1)) u_div_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v1),
        .i_num   (r_num1),
        .i_den   (r_den1),
        .i_side  ({r_tir1, r_pass1}),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_side  (d1_side)
    );

    fdr_sqrt #(.RB(F + 1), .SW(SW1)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (d1_v),
        .i_x     ({1'b0, d1_q}),
        .i_side  (d1_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic               sq_tir;
    logic [ETA_W-1:0]   sq_eta;
    logic [CLAMP_W-1:0] sq_c;
    logic [29:0]        sq_ec;
    assign {sq_tir, sq_eta, sq_c, sq_ec} = sq_side;

    // stage 2a: eta * cos_i
    logic               r_v2;
    logic               r_tir2;
    logic [F:0]         r_ci2;
    logic [F+16:0]      r_eci2;
    logic [CLAMP_W-1:0] r_c2;
    logic [29:0]        r_ec2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tir2 <= sq_tir;
            r_ci2  <= sq_root;
            r_eci2 <= sq_eta * sq_root;
            r_c2   <= sq_c;
            r_ec2  <= sq_ec;
        end
    end

    // stage 2b: amplitude ratio numerators and denominators
    logic           r_v3;
    logic           r_tir3;
    logic [F:0]     r_ci3;
    logic [NWP-1:0] r_pn3, r_pd3;
    logic [NWS-1:0] r_sn3, r_sd3;
    logic [NWP-1:0] ap, bp;
    logic [NWS-1:0] as_, bs;

    assign ap  = NWP'({r_ci2, 26'd0});
    assign bp  = NWP'({r_ec2, F'(0)});
    assign as_ = NWS'(r_eci2);
    assign bs  = NWS'({r_c2, (F-2)'(0)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tir3 <= r_tir2;
            r_ci3  <= r_ci2;
            r_pn3  <= (ap >= bp) ? ap - bp : bp - ap;
            r_pd3  <= ap + bp;
            r_sn3  <= (as_ >= bs) ? as_ - bs : bs - as_;
            r_sd3  <= as_ + bs;
        end
    end

    logic         dp_v, ds_v;
    logic [F:0]   dp_q, ds_q;
    logic         dp_tir;
    logic [F:0]   ds_ci;

    fdr_div #(.NW(NWP), .QB(F), .SW(1)) u_div_parl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v3),
        .i_num   (r_pn3),
        .i_den   (r_pd3),
        .i_side  (r_tir3),
        .o_valid (dp_v),
        .o_quot  (dp_q),
        .o_side  (dp_tir)
    );

    fdr_div #(.NW(NWS), .QB(F), .SW(F + 1)) u_div_perp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v3),
        .i_num   (r_sn3),
        .i_den   (r_sd3),
        .i_side  (r_ci3),
        .o_valid (ds_v),
        .o_quot  (ds_q),
        .o_side  (ds_ci)
    );

    // stage 3: squares
    logic             r_v4;
    logic             r_tir4;
    logic [F:0]       r_ci4;
    logic [2*F+1:0]   r_rp2, r_rs2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v4 <= dp_v && ds_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tir4 <= dp_tir;
            r_ci4  <= ds_ci;
            r_rp2  <= dp_q * dp_q;
            r_rs2  <= ds_q * ds_q;
        end
    end

    // stage 4: mean, saturate, output register
    logic [SQW-1:0] sum_sq;
    logic [SQW-1:0] mean_sq;
    logic [OUT_W-1:0] refl_sat, ci_sat;
    logic             r_o_valid;
    logic [OUT_W-1:0] r_refl, r_ci;
    logic             r_tir;

    always_comb begin
        sum_sq   = SQW'(r_rp2) + SQW'(r_rs2);
        mean_sq  = sum_sq >> (F + 1);
        refl_sat = (mean_sq > SQW'(OUT_MAX)) ? OUT_MAX : mean_sq[OUT_W-1:0];
        if (F + 1 > OUT_W) begin
            ci_sat = ((r_ci4 >> OUT_W) != '0) ? OUT_MAX : OUT_W'(r_ci4);
        end else begin
            ci_sat = OUT_W'(r_ci4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tir  <= r_tir4;
            r_refl <= r_tir4 ? ONE_SAT : refl_sat;
            r_ci   <= r_tir4 ? '0 : ci_sat;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_reflectance      = r_refl;
    assign o_cos_incident     = r_ci;
    assign o_total_reflection = r_tir;

    a_tir_cos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_total_reflection |-> o_cos_incident == '0)
        else $error("cos_incident nonzero on total reflection");

    a_tir_refl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_total_reflection |-> o_reflectance == ONE_SAT)
        else $error("reflectance not one on total reflection");

    a_refl_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_reflectance <= ONE_SAT)
        else $error("reflectance above one");

    a_lanes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_v == ds_v)
        else $error("ratio dividers out of step");
endmodule
